>>> design/asa_pkg.sv
// asa_pkg: field widths, register indexes and shared types of the ADC scan averager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package asa_pkg;

   // Payload and state widths
   localparam int SAMPLE_W  = 10;
   localparam int CHAN_W    = 3;
   localparam int AVG_W     = 10;
   localparam int SPA_W     = 8;
   localparam int MASK_W    = 8;
   localparam int SUM_W     = 18;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_MASK    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_AVG = 2'd1;

   // Reset values of the configuration registers
   localparam logic [MASK_W-1:0] MASK_RESET = 8'd1;
   localparam logic [SPA_W-1:0]  SPA_RESET  = 8'd1;

   // Largest average reported
   localparam logic [AVG_W-1:0] AVG_MAX = 10'd1022;

   // Divider start request
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [SPA_W-1:0] divisor;
   } div_req_type;

   // Divider completion
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> design/asa_divider.sv
// asa_divider: restoring divider, one quotient bit per clock.
// Depends on asa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module asa_divider (
   input  logic                clock,
   input  logic                reset,
   input  asa_pkg::div_req_type div_req,
   output asa_pkg::div_rsp_type div_rsp
);
   import asa_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     dvd_ff, dvd_in;
   logic [SPA_W-1:0]     rem_ff, rem_in;
   logic [SPA_W-1:0]     dsr_ff, dsr_in;

   logic [SPA_W:0]       shifted;
   logic [SPA_W:0]       diff;
   logic                 fits;

   // Shift in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         // load operands and clear the partial remainder
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // one restoring step; the quotient bit enters at the bottom
         dvd_in = {dvd_ff[SUM_W-2:0], fits};
         rem_in = fits ? diff[SPA_W-1:0] : shifted[SPA_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

>>> design/adc_scan_averager_top.sv
// adc_scan_averager_top: per-channel sample accumulation, averaging and scan stepping.
// Depends on asa_pkg and asa_divider.
`timescale 1ns / 1ps

// Each req transaction carries one conversion of the active channel. While fewer than
// samples_per_average samples are summed, the sample (less one, floored at zero) is added to
// the running sum and the block stays idle. The following conversion is discarded and closes
// the average: it starts an 18-step bit-serial divider, rsp_valid rises once the divider
// reports done, and req_ready stays low meanwhile. A closing conversion is also held off
// while an earlier result has not been taken. The result carries the channel, the truncated
// average (capped at 1022, zero when samples_per_average is zero) and the next enabled
// channel in cyclic order, which becomes active. Configuration writes take effect at once and
// leave sum, count and channel alone.
module adc_scan_averager_top #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [asa_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [asa_pkg::CHAN_W-1:0]      rsp_channel,
   output logic [asa_pkg::AVG_W-1:0]       rsp_average,
   output logic [asa_pkg::CHAN_W-1:0]      rsp_next_channel,
   input  logic                            csr_write_en,
   input  logic [asa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import asa_pkg::*;

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SW     = CH_W + 1;
   localparam int CAND_W = (SW > 4) ? SW : 4;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type          state_ff, state_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [SPA_W-1:0]   spa_ff, spa_in;
   logic [SPA_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CHAN_W-1:0]  active_ff, active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_channel_ff, rsp_channel_in;
   logic [AVG_W-1:0]   rsp_average_ff, rsp_average_in;
   logic [CHAN_W-1:0]  rsp_next_ff, rsp_next_in;

   logic               close_now;
   logic               accept;
   logic [SAMPLE_W-1:0] corr;
   logic [CHAN_W-1:0]  next_chan;
   logic [AVG_W-1:0]   avg_sat;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Handshake: a closing conversion needs the result register free
   assign close_now = (count_ff >= spa_ff);
   assign req_ready = (state_ff == ST_IDLE) && (!close_now || !rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   // Offset correction, floored at zero
   assign corr = (req_sample == '0) ? '0 : req_sample - 1'b1;

   // Search the next enabled channel after the active one, wrapping; stay if none
   always_comb begin
      logic [CAND_W-1:0] cur;
      logic [CAND_W-1:0] cand;
      next_chan = active_ff;
      cur       = CAND_W'(active_ff);
      for (int k = NUM_CHANNELS - 1; k >= 1; k--) begin
         cand = cur + CAND_W'(k);
         if (cand >= CAND_W'(NUM_CHANNELS)) begin
            cand = cand - CAND_W'(NUM_CHANNELS);
         end
         if ((cand < CAND_W'(MASK_W)) && mask_ff[cand[2:0]]) begin
            next_chan = cand[CHAN_W-1:0];
         end
      end
   end

   // Divider launch and result saturation
   assign div_req.start    = accept && close_now;
   assign div_req.dividend = sum_ff;
   assign div_req.divisor  = spa_ff;

   assign avg_sat = (spa_ff == '0) ? '0 :
                    (div_rsp.quotient > SUM_W'(AVG_MAX)) ? AVG_MAX :
                    div_rsp.quotient[AVG_W-1:0];

   always_comb begin
      state_in       = state_ff;
      mask_in        = mask_ff;
      spa_in         = spa_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_average_in = rsp_average_ff;
      rsp_next_in    = rsp_next_ff;

      // Configuration writes; unknown indexes drop
      if (csr_write_en) begin
         case (csr_index)
            REG_CHANNEL_MASK:    mask_in = csr_wdata[MASK_W-1:0];
            REG_SAMPLES_PER_AVG: spa_in  = csr_wdata[SPA_W-1:0];
            default: ;
         endcase
      end

      // Release the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (close_now) begin
                  // discard the sample, advance the channel, start the divide
                  rsp_channel_in = active_ff;
                  rsp_next_in    = next_chan;
                  active_in      = next_chan;
                  count_in       = '0;
                  sum_in         = '0;
                  state_in       = ST_DIVIDE;
               end else begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(corr);
               end
            end
         end
         ST_DIVIDE: begin
            // hold until the quotient is ready, then present the result
            if (div_rsp.done) begin
               rsp_average_in = avg_sat;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= MASK_RESET;
         spa_ff       <= SPA_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         spa_ff       <= spa_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_channel_ff <= rsp_channel_in;
      rsp_average_ff <= rsp_average_in;
      rsp_next_ff    <= rsp_next_in;
   end

   asa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_next_channel = rsp_next_ff;

endmodule

>>> design/asa_checker.sv
// asa_checker: port-level assertions for adc_scan_averager_top, attached by bind.
// Depends on asa_pkg for widths and the average cap.
`timescale 1ns / 1ps

module asa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [asa_pkg::CHAN_W-1:0]      rsp_channel,
   input logic [asa_pkg::AVG_W-1:0]       rsp_average,
   input logic [asa_pkg::CHAN_W-1:0]      rsp_next_channel
);
   import asa_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) &&
         $stable(rsp_channel) && $stable(rsp_next_channel))
      else $error("stalled result changed");

   // Average never exceeds the cap
   a_avg_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average <= AVG_MAX)
      else $error("average above cap");

   // Results are spaced by the divide, never back to back
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result presented right after a taken result");

   // A new result only follows a cycle with the input side stalled
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a preceding divide");

endmodule

bind adc_scan_averager_top asa_checker u_asa_checker (.*);

>>> bench/adc_scan_averager_top_tb.sv
// Self-checking bench for adc_scan_averager_top: directed table, then random scan segments.
// Depends on asa_pkg and the adc_scan_averager_top RTL; results are checked by an in-bench model.
`timescale 1ns / 1ps

module adc_scan_averager_top_tb;
   import asa_pkg::*;

   localparam int NUM_CH       = 8;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int NUM_SEGS     = 30;
   localparam int SEG_ITEMS    = 48;

   // Indexes past the defined registers; the block ignores them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [AVG_W-1:0]  average;
      logic [CHAN_W-1:0] next_channel;
   } scan_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [SAMPLE_W-1:0]  value;
      logic                 typed;
      scan_result_type      want;
   } stim_row_type;

   localparam scan_result_type NO_RESULT = '0;

   // Directed stimulus; rows with typed set carry the result read straight off the scan rules
   localparam int NUM_ROWS = 34;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // defaults after reset: channel 0 only, one sample per average
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd0,    1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b1, '{3'd0, 10'd0, 3'd0}},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd0,    1'b1, '{3'd0, 10'd1022, 3'd0}},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd0,    1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1,    1'b1, '{3'd0, 10'd0, 3'd0}},
      // all channels, two samples: average reaches the cap
      '{ROW_CSR,    REG_CHANNEL_MASK,    10'hFF, 1'b0, NO_RESULT},
      '{ROW_CSR,    REG_SAMPLES_PER_AVG, 10'd2,  1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd700,  1'b1, '{3'd0, 10'd1022, 3'd1}},
      // top channel only: search moves up to channel 7
      '{ROW_CSR,    REG_CHANNEL_MASK,    10'h80, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd3,    1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd4,    1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd9,    1'b1, '{3'd1, 10'd2, 3'd7}},
      // empty mask: stay on the current channel
      '{ROW_CSR,    REG_CHANNEL_MASK,    10'h00, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd10,   1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd10,   1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd0,    1'b1, '{3'd7, 10'd9, 3'd7}},
      // zero samples per average: every conversion closes with average 0
      '{ROW_CSR,    REG_SAMPLES_PER_AVG, 10'd0,  1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd512,  1'b1, '{3'd7, 10'd0, 3'd7}},
      // count left above a lowered setting: next conversion closes, average capped
      '{ROW_CSR,    REG_SAMPLES_PER_AVG, 10'd4,  1'b0, NO_RESULT},
      '{ROW_CSR,    REG_CHANNEL_MASK,    10'h55, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b0, NO_RESULT},
      '{ROW_CSR,    REG_SAMPLES_PER_AVG, 10'd1,  1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1023, 1'b1, '{3'd7, 10'd1022, 3'd0}},
      // writes to unused indexes change nothing
      '{ROW_CSR,    REG_SPARE_2,         10'hAB, 1'b0, NO_RESULT},
      '{ROW_CSR,    REG_SPARE_3,         10'h00, 1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd50,   1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd77,   1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd2,    1'b0, NO_RESULT},
      '{ROW_SAMPLE, REG_CHANNEL_MASK, 10'd1022, 1'b0, NO_RESULT}
   };

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [AVG_W-1:0]      rsp_average;
   logic [CHAN_W-1:0]     rsp_next_channel;
   logic                  csr_write_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   // Model state: configuration plus accumulator
   logic [MASK_W-1:0]  scan_mask;
   logic [SPA_W-1:0]   spa_setting;
   logic [SPA_W-1:0]   acc_count;
   logic [SUM_W-1:0]   acc_sum;
   logic [CHAN_W-1:0]  scan_chan;

   scan_result_type pending_avgs [$];
   int           fault_count   = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   bit           hold_req      = 1'b0;

   adc_scan_averager_top #(
      .NUM_CHANNELS (NUM_CH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_average      (rsp_average),
      .rsp_next_channel (rsp_next_channel),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Next enabled channel after cur, wrapping; falls back to cur when none is found
   function automatic logic [CHAN_W-1:0] next_enabled_channel(input logic [CHAN_W-1:0] cur);
      int c;
      c = int'(cur) % NUM_CH;
      for (int i = 0; i < NUM_CH; i++) begin
         c = (c + 1) % NUM_CH;
         if (c < MASK_W && scan_mask[c])
            return c[CHAN_W-1:0];
      end
      return cur;
   endfunction

   // Fold one accepted conversion into the accumulator; close the average when the count is met
   function automatic void fold_sample(input logic [SAMPLE_W-1:0] s, output bit produced,
                                       output scan_result_type res);
      int unsigned quot;
      produced = 1'b0;
      res      = NO_RESULT;
      if (acc_count < spa_setting) begin
         acc_count = acc_count + 1'b1;
         acc_sum   = acc_sum + ((s != '0) ? SUM_W'(s - 1'b1) : '0);
      end else begin
         if (spa_setting == '0) begin
            quot = 0;
         end else begin
            quot = 32'(acc_sum / SUM_W'(spa_setting));
            if (quot > 32'(AVG_MAX))
               quot = 32'(AVG_MAX);
         end
         res.channel      = scan_chan;
         res.average      = quot[AVG_W-1:0];
         res.next_channel = next_enabled_channel(scan_chan);
         scan_chan        = res.next_channel;
         acc_count        = '0;
         acc_sum          = '0;
         produced         = 1'b1;
      end
   endfunction

   // Offer one conversion, hold it until taken, then record what it should produce
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                              input scan_result_type want);
      bit              produced;
      scan_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      fold_sample(s, produced, res);
      if (typed)
         pending_avgs.push_back(want);
      else if (produced)
         pending_avgs.push_back(res);
   endtask

   // Drop valid, wait for every outstanding average, then let the divider run out
   task automatic settle(input int drain);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_avgs.size() != 0)
         @(posedge clock);
      repeat (drain) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_CHANNEL_MASK)
         scan_mask = data;
      else if (idx == REG_SAMPLES_PER_AVG)
         spa_setting = data;
      @(posedge clock);
   endtask

   // Compare one result transaction against the oldest pending average
   task automatic check_result();
      scan_result_type want;
      if (pending_avgs.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: unexpected result ch=%0d avg=%0d next=%0d", $realtime,
                     rsp_channel, rsp_average, rsp_next_channel);
      end else begin
         want = pending_avgs.pop_front();
         if (rsp_channel !== want.channel || rsp_average !== want.average ||
             rsp_next_channel !== want.next_channel) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: mismatch exp ch=%0d avg=%0d next=%0d got ch=%0d avg=%0d next=%0d",
                        $realtime, want.channel, want.average, want.next_channel,
                        rsp_channel, rsp_average, rsp_next_channel);
         end
      end
   endtask

   // Result side: check each transaction, then pick ready for the next cycle
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("adc_scan_averager_top test failed");
      $finish;
   end

   // Stimulus
   initial begin
      logic [SAMPLE_W-1:0] s;
      logic [MASK_W-1:0]   m;
      logic [SPA_W-1:0]    n;

      scan_mask   = MASK_RESET;
      spa_setting = SPA_RESET;
      acc_count   = '0;
      acc_sum     = '0;
      scan_chan   = '0;
      send_idle_pct = 38;
      recv_idle_pct = 73;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            settle(DRAIN_CYCLES);
            csr_write(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value[CSR_DATA_W-1:0]);
         end else begin
            send_sample(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         end
      end

      // Random segments, each with its own settings; idle pattern advances by thirds
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         settle(DRAIN_CYCLES);
         if (seg < NUM_SEGS / 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 73;
         end else if (seg < 2 * NUM_SEGS / 3) begin
            send_idle_pct = 73;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case ($urandom_range(0, 9))
            0:       m = 8'h00;
            1:       m = 8'hFF;
            2:       m = 8'h01 << $urandom_range(0, 7);
            default: m = MASK_W'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 19))
            0:       n = 8'd0;
            1:       n = 8'd255;
            2:       n = SPA_W'($urandom_range(9, 40));
            default: n = SPA_W'($urandom_range(1, 8));
         endcase
         // Backpressure segments: short averages so results pile up behind the stall
         if (seg % 10 == 4) begin
            m = 8'hFF;
            n = 8'd1;
         end
         csr_write(REG_CHANNEL_MASK, m);
         csr_write(REG_SAMPLES_PER_AVG, n);
         if ($urandom_range(0, 9) == 0)
            csr_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      CSR_DATA_W'($urandom_range(0, 255)));
         if (seg % 10 == 4)
            hold_req = 1'b1;

         for (int k = 0; k < SEG_ITEMS; k++) begin
            // Pause the sender mid-segment until all results are in
            if (seg % 6 == 2 && k == SEG_ITEMS / 2)
               settle(0);
            case ($urandom_range(0, 9))
               0:       s = 10'd0;
               1:       s = 10'd1023;
               2:       s = SAMPLE_W'($urandom_range(1, 2));
               3:       s = 10'd1022;
               default: s = SAMPLE_W'($urandom_range(0, 1023));
            endcase
            send_sample(s, 1'b0, NO_RESULT);
         end
      end

      settle(DRAIN_CYCLES);
      fault_count += pending_avgs.size();
      if (fault_count == 0)
         $display("adc_scan_averager_top test passed");
      else
         $display("adc_scan_averager_top test failed");
      $finish;
   end

endmodule
